@@ rtl/xsc_pkg.sv @@
// Shared types, constants and the xorshift mixing function for the
// xorshift stream cipher with tag. No dependencies.
`timescale 1ns / 1ps

package xsc_pkg;

	localparam logic [63:0] INNER_PAD = 64'h4613_A6F6_B459_51C6;
	localparam logic [63:0] OUTER_PAD = 64'h29E8_FF49_49B2_863D;
	localparam int unsigned SHIFT_A = 13;
	localparam int unsigned SHIFT_B = 7;
	localparam int unsigned SHIFT_C = 17;
	localparam logic [5:0] COUNT_LAST = 6'd62;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam int unsigned IN_TDATA_W  = 72;
	localparam int unsigned OUT_TDATA_W = 80;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_DATA  = 2'd1;
	localparam logic [1:0] OP_IV    = 2'd2;
	localparam logic [1:0] OP_END   = 2'd3;

	localparam logic [1:0] REG_KEY    = 2'd0;
	localparam logic [1:0] REG_DECRYPT = 2'd1;

	typedef enum logic [1:0] {
		KIND_START,
		KIND_DATA,
		KIND_IV,
		KIND_END
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic [63:0] given_tag;
	} item_t;

	typedef struct packed {
		logic [63:0] cipher_key;
		logic        decrypt_mode;
	} cfg_t;

	function automatic logic [63:0] mix64(input logic [63:0] v);
		logic [63:0] a;
		logic [63:0] b;
		a = v ^ (v << SHIFT_A);
		b = a ^ (a >> SHIFT_B);
		return b ^ (b << SHIFT_C);
	endfunction

endpackage

@@ rtl/xorshift_stream_cipher_with_tag.sv @@
// An accepted input item is written into the queue, then executed into the output
// register; an output stall can hold it in the queue in between. Throughput: one item
// per cycle while the output register is empty or being drained; each item's state
// update (two xorshifts, a 64-bit shift of the plaintext byte and xors) completes in the
// execute step. tready stays low while the queue is full, even in a cycle with a pop.
// Reset (arst_n low, asynchronous): key 1, encrypt mode, seed 1, tag 0, count 0, queue and
// output register empty; config writes are accepted every cycle. Depends on xsc_pkg,
// xsc_front and xsc_back.
`timescale 1ns / 1ps

module xorshift_stream_cipher_with_tag #(
	parameter int unsigned QUEUE_DEPTH = xsc_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input item channel
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [1:0]                      s_tuser,  // [1:0] opcode
	input  logic [xsc_pkg::IN_TDATA_W-1:0]  s_tdata,  // [7:0] data_byte, [71:8] given_tag
	// result item channel
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [1:0]                      m_tuser,  // [0] byte_valid, [1] tag_valid
	output logic [xsc_pkg::OUT_TDATA_W-1:0] m_tdata,  // [7:0] out_byte, [71:8] final_tag,
	                                                  // [72] tag_match, [79:73] zero
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [1:0]                      cfg_index,
	input  logic [63:0]                     cfg_data
);

	xsc_pkg::cfg_t  cfg_q;
	xsc_pkg::item_t head;
	logic           head_valid;
	logic           pop;

	// Configuration registers; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cipher_key   <= 64'd1;
			cfg_q.decrypt_mode <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				xsc_pkg::REG_KEY:     cfg_q.cipher_key   <= cfg_data;
				xsc_pkg::REG_DECRYPT: cfg_q.decrypt_mode <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Front: accept and classify items, hold them in the queue.
	xsc_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tuser    (s_tuser),
		.s_tdata    (s_tdata),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	// Back: advance the cipher state and register one result per item.
	xsc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tuser    (m_tuser),
		.m_tdata    (m_tdata)
	);

endmodule

@@ rtl/xsc_front.sv @@
// Front end: accepts input items, classifies the opcode and holds them in a
// short queue for the back end. Depends on xsc_pkg.
`timescale 1ns / 1ps

module xsc_front #(
	parameter int unsigned DEPTH = xsc_pkg::QUEUE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [1:0]                       s_tuser,
	input  logic [xsc_pkg::IN_TDATA_W-1:0]   s_tdata,
	output xsc_pkg::item_t                   head,
	output logic                             head_valid,
	input  logic                             pop
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	xsc_pkg::item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	xsc_pkg::item_t   item_in;
	logic             push;
	logic             do_pop;

	always_comb begin
		case (s_tuser)
			xsc_pkg::OP_START: item_in.kind = xsc_pkg::KIND_START;
			xsc_pkg::OP_DATA:  item_in.kind = xsc_pkg::KIND_DATA;
			xsc_pkg::OP_IV:    item_in.kind = xsc_pkg::KIND_IV;
			xsc_pkg::OP_END:   item_in.kind = xsc_pkg::KIND_END;
			default:           item_in.kind = xsc_pkg::KIND_END;
		endcase
		item_in.data_byte = s_tdata[7:0];
		item_in.given_tag = s_tdata[71:8];
	end

	assign s_tready   = (count_q != CNT_FULL);
	assign push       = s_tvalid && s_tready;
	assign head_valid = (count_q != '0);
	assign do_pop     = pop && head_valid;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/xsc_back.sv @@
// Back end: holds generator seed, running tag and shift count; executes one queued
// item per cycle unless the output stalls and drives the output register. Depends on xsc_pkg.
`timescale 1ns / 1ps

module xsc_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  xsc_pkg::cfg_t                   cfg,
	input  xsc_pkg::item_t                  head,
	input  logic                            head_valid,
	output logic                            pop,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [1:0]                      m_tuser,
	output logic [xsc_pkg::OUT_TDATA_W-1:0] m_tdata
);

	logic [63:0] seed_q;
	logic [63:0] tag_q;
	logic [5:0]  count_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        byte_valid_q;
	logic [63:0] final_tag_q;
	logic        tag_valid_q;
	logic        tag_match_q;

	logic [63:0] seed_mixed;
	logic [7:0]  cipher_byte;
	logic [7:0]  plain;
	logic [5:0]  count_next;
	logic [63:0] tag_mixed;
	logic [63:0] fin;
	logic        is_byte;

	// advance when the output register is empty or being drained
	assign pop = head_valid && (!out_valid_q || m_tready);
	assign is_byte = (head.kind == xsc_pkg::KIND_DATA) || (head.kind == xsc_pkg::KIND_IV);

	always_comb begin
		seed_mixed  = xsc_pkg::mix64(seed_q);
		cipher_byte = head.data_byte ^ seed_mixed[7:0];
		plain       = cfg.decrypt_mode ? cipher_byte : head.data_byte;
		count_next  = (count_q == xsc_pkg::COUNT_LAST) ? '0 : count_q + 1'b1;
		tag_mixed   = xsc_pkg::mix64(tag_q ^ ({56'd0, plain} << count_next));
		fin         = xsc_pkg::mix64(tag_q ^ cfg.cipher_key ^ xsc_pkg::OUTER_PAD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= 64'd1;
			tag_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				case (head.kind)
					xsc_pkg::KIND_START: begin
						seed_q  <= (cfg.cipher_key > 64'd1) ? cfg.cipher_key : 64'd1;
						tag_q   <= xsc_pkg::mix64(cfg.cipher_key ^ xsc_pkg::INNER_PAD);
						count_q <= '0;
					end
					xsc_pkg::KIND_DATA, xsc_pkg::KIND_IV: begin
						seed_q  <= seed_mixed ^ tag_mixed;
						tag_q   <= tag_mixed;
						count_q <= count_next;
					end
					default: begin
					end
				endcase
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_byte_q   <= is_byte ? cipher_byte : 8'd0;
			byte_valid_q <= (head.kind == xsc_pkg::KIND_DATA)
				|| ((head.kind == xsc_pkg::KIND_IV) && !cfg.decrypt_mode);
			tag_valid_q  <= (head.kind == xsc_pkg::KIND_END);
			final_tag_q  <= (head.kind == xsc_pkg::KIND_END) ? fin : 64'd0;
			tag_match_q  <= (head.kind == xsc_pkg::KIND_END) && (fin == head.given_tag);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = {tag_valid_q, byte_valid_q};
	assign m_tdata  = {7'd0, tag_match_q, final_tag_q, out_byte_q};

endmodule
